### sv/pem_pkg.sv
// Package for the Prewitt edge magnitude block: widths and shared types.
// Used by all modules of the block; depends on nothing.
`default_nettype none
package pem_pkg;
  localparam int PixW  = 8;
  localparam int RootW = 8;
  localparam int SqW   = 16;
  localparam int CfgIdxW = 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'd1;

  // Beat handed from one root cell to the next.
  typedef struct packed {
    logic             vld;
    logic [SqW:0]     rem_sq;   // radicand, 17 bits, saturation via top bit
    logic [RootW-1:0] root;
    logic [9:0]       row;
    logic [7:0]       col;
    logic             last;
  } pem_cell_t;
endpackage
`default_nettype wire

### sv/pem_root_cell.sv
// One bit step of the integer square root chain.
// Depends on pem_pkg.
`default_nettype none
module pem_root_cell #(
  parameter int BitPos = 7
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                adv,
  input  pem_pkg::pem_cell_t cin,
  output pem_pkg::pem_cell_t cout
);
  import pem_pkg::*;

  logic [RootW-1:0] trial;
  logic [SqW:0]     trial_sq;

  // Try setting this bit of the root and keep it if its square still fits or the radicand is saturated.
  always_comb begin
    trial    = cin.root | RootW'(1 << BitPos);
    trial_sq = (SqW+1)'(trial) * (SqW+1)'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.vld <= 1'b0;
    end else if (adv) begin
      cout.vld <= cin.vld;
    end
    if (adv) begin
      cout.rem_sq <= cin.rem_sq;
      cout.row    <= cin.row;
      cout.col    <= cin.col;
      cout.last   <= cin.last;
      if (cin.rem_sq[SqW] || trial_sq <= cin.rem_sq) begin
        cout.root <= trial;
      end else begin
        cout.root <= cin.root;
      end
    end
  end
endmodule
`default_nettype wire

### sv/pem_window.sv
// Line buffers, 3x3 window, raster counters and Prewitt gradient stage.
// Depends on pem_pkg.
`default_nettype none
module pem_window #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     adv,
  input  wire                     take,
  input  wire [pem_pkg::PixW-1:0] pixel,
  input  wire                     restart,
  input  wire [8:0]               frame_width,
  input  wire [10:0]              frame_height,
  output pem_pkg::pem_cell_t      cout
);
  import pem_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);

  logic [PixW-1:0] upper_mem  [MAX_WIDTH];
  logic [PixW-1:0] middle_mem [MAX_WIDTH];
  logic [PixW-1:0] win [3][3];
  logic [ColW:0] col_cnt, col_next, c_eff, w_eff;
  logic [RowW:0] row_cnt, row_next, r_eff, h_eff;
  logic [PixW-1:0] up_rd, mid_rd;

  // Clamp the dimensions to the supported range and work out the next raster position.
  always_comb begin
    if (frame_width < 9'd3) w_eff = (ColW+1)'(3);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = (ColW+1)'(MAX_WIDTH);
    else w_eff = (ColW+1)'(frame_width);
    if (frame_height < 11'd3) h_eff = (RowW+1)'(3);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = (RowW+1)'(MAX_HEIGHT);
    else h_eff = (RowW+1)'(frame_height);
    c_eff = (col_cnt >= w_eff) ? '0 : col_cnt;
    r_eff = (row_cnt >= h_eff) ? '0 : row_cnt;
    col_next = c_eff + 1'b1;
    row_next = r_eff;
    if (col_next >= w_eff) begin
      col_next = '0;
      row_next = r_eff + 1'b1;
      if (row_next >= h_eff) row_next = '0;
    end
  end

  // Line buffers rotate the column on each pixel. Both are read every cycle
  // at the column of the next pixel; the input idles after each beat, so the
  // registered data is current when the next pixel comes.
  always_ff @(posedge clk) begin
    up_rd  <= upper_mem[c_eff[ColW-1:0]];
    mid_rd <= middle_mem[c_eff[ColW-1:0]];
    if (take) begin
      upper_mem[c_eff[ColW-1:0]]  <= mid_rd;
      middle_mem[c_eff[ColW-1:0]] <= pixel;
    end
  end

  // Window shift and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) win[k][j] <= '0;
      end
    end else if (restart) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (take) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= up_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= pixel;
    end
  end

  // Window centre position for the pixel just taken, for the gradient stage.
  logic          pend, pend_last;
  logic [9:0]    pend_row;
  logic [7:0]    pend_col;
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (take) begin
      pend <= (r_eff >= 2) && (c_eff >= 2);
    end else if (adv) begin
      pend <= 1'b0;
    end
    if (take) begin
      pend_row  <= 10'(r_eff - 1'b1);
      pend_col  <= 8'(c_eff - 1'b1);
      pend_last <= (r_eff == h_eff - 1'b1) && (c_eff == w_eff - 1'b1);
    end
  end

  // Gradients and their squared magnitude.
  logic signed [10:0] gx, gy;
  logic [9:0]  ax, ay;
  logic [20:0] s;
  always_comb begin
    gx = 11'sd0;
    gy = 11'sd0;
    for (int k = 0; k < 3; k++) begin
      gx = gx + $signed({3'b0, win[k][2]}) - $signed({3'b0, win[k][0]});
      gy = gy + $signed({3'b0, win[0][k]}) - $signed({3'b0, win[2][k]});
    end
    ax = gx[10] ? 10'(-gx) : 10'(gx);
    ay = gy[10] ? 10'(-gy) : 10'(gy);
    s  = 21'(ax) * 21'(ax) + 21'(ay) * 21'(ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.vld <= 1'b0;
    end else if (adv) begin
      cout.vld <= pend;
    end
    if (adv) begin
      cout.rem_sq <= (s[20:SqW] != '0) ? {1'b1, SqW'(0)} : {1'b0, s[SqW-1:0]};
      cout.root   <= '0;
      cout.row    <= pend_row;
      cout.col    <= pend_col;
      cout.last   <= pend_last;
    end
  end
endmodule
`default_nettype wire

### sv/prewitt_edge_magnitude.sv
// Top level of the Prewitt edge magnitude block.
// Depends on pem_pkg, pem_window and pem_root_cell.
`default_nettype none
// Takes one 8-bit pixel per beat in raster order and emits one beat per
// interior pixel with the saturated Prewitt gradient magnitude. After each
// accepted pixel the input idles, which gives the line buffers a registered
// read at the next column, so pixels are never accepted back to back. A
// result passes a position register, one gradient stage and a chain of eight
// square-root bit cells; the chain stalls as a whole when the output is
// held. A configuration beat holds off pixel input in its own cycle, leaves
// an idle input gap after it as a pixel does, and restarts the frame.
module prewitt_edge_magnitude #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,    // pixel[7:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,    // edge_res[7:0], out_row[17:8], out_col[25:18], zero
  output logic        m_tlast,    // frame_end
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import pem_pkg::*;

  pem_cell_t chain [RootW+1];
  logic adv, take, cfg_wr, gap;
  logic [8:0]  frame_width;
  logic [10:0] frame_height;

  // Chain advances unless a finished result waits at the output.
  assign adv       = !(chain[RootW].vld && !m_tready);
  assign s_tready  = adv && !gap && !cfg_valid;
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  // Idle input gap after each pixel or register beat; it ends when the chain advances.
  always_ff @(posedge clk) begin
    if (rst) gap <= 1'b0;
    else if (take || cfg_wr) gap <= 1'b1;
    else if (adv) gap <= 1'b0;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 9'd200;
      frame_height <= 11'd200;
    end else if (cfg_wr) begin
      case (cfg_index)
        RegWidth:  frame_width  <= cfg_data[8:0];
        RegHeight: frame_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  pem_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
    .clk, .rst, .adv, .take, .pixel(s_tdata), .restart(cfg_wr),
    .frame_width, .frame_height, .cout(chain[0])
  );

  for (genvar g = 0; g < RootW; g++) begin : g_cell
    pem_root_cell #(.BitPos(RootW-1-g)) u_cell (
      .clk, .rst, .adv, .cin(chain[g]), .cout(chain[g+1])
    );
  end

  assign m_tvalid = chain[RootW].vld;
  assign m_tdata  = {6'd0, chain[RootW].col, chain[RootW].row, chain[RootW].root};
  assign m_tlast  = chain[RootW].last;
endmodule
`default_nettype wire

### sv/prewitt_edge_magnitude_chk.sv
// Port-level checker for the Prewitt edge magnitude block, with its bind.
// Depends on prewitt_edge_magnitude.
`default_nettype none
module prewitt_edge_magnitude_chk (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire        m_tlast
);
  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");
  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:26] == 6'd0)
    else $error("padding not zero");
  // Centre never on the top row or left column.
  a_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:8] != 10'd0 && m_tdata[25:18] != 8'd0)
    else $error("border position emitted");
  // Input is never taken back to back.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back to back input");
endmodule

bind prewitt_edge_magnitude prewitt_edge_magnitude_chk u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
`default_nettype wire

### tb/sv/pem_checker.sv
// Checker for the Prewitt edge magnitude block: watches the pixel, result and
// register channels, predicts each result and compares it. Depends on pem_pkg.
`timescale 1ns / 100ps
module pem_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [7:0]  s_tdata,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [31:0] m_tdata,
  input  wire         m_tlast,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import pem_pkg::*;

  typedef struct packed {
    logic [7:0] mag;
    logic [9:0] row;
    logic [7:0] col;
    logic       last;
  } edge_beat_t;

  logic [8:0]  width_reg;
  logic [10:0] height_reg;
  logic [7:0]  upper_buf [256];
  logic [7:0]  middle_buf [256];
  logic [7:0]  win [3][3];
  int          row_pos, col_pos;
  edge_beat_t  expected_edges[$];

  assign pending = expected_edges.size();

  // Integer square root, saturated to 255.
  function automatic logic [7:0] root_sat(int unsigned s);
    int unsigned r;
    int unsigned t;
    r = 0;
    if (s >= 65536) return 8'd255;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // Advance the window with one pixel and queue its result if interior.
  task automatic push_pixel(logic [7:0] px);
    int w, h, c, r, gx, gy;
    edge_beat_t e;
    w = (width_reg < 3) ? 3 : (width_reg > 256) ? 256 : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > 1024) ? 1024 : height_reg;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_buf[c];
    win[1][2] = middle_buf[c];
    win[2][2] = px;
    upper_buf[c] = middle_buf[c];
    middle_buf[c] = px;
    if (r >= 2 && c >= 2) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < 3; k++) begin
        gx += int'(win[k][2]) - int'(win[k][0]);
        gy += int'(win[0][k]) - int'(win[2][k]);
      end
      e.mag = root_sat(gx * gx + gy * gy);
      e.row = 10'(r - 1);
      e.col = 8'(c - 1);
      e.last = (r == h - 1) && (c == w - 1);
      expected_edges.push_back(e);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Track the channels at each rising edge.
  always @(posedge clk) begin
    edge_beat_t got, want;
    if (rst) begin
      width_reg <= 9'd200;
      height_reg <= 11'd200;
      row_pos = 0;
      col_pos = 0;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win[k][j] = '0;
      expected_edges.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegWidth) width_reg <= cfg_data[8:0];
        else height_reg <= cfg_data[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      if (s_tvalid && s_tready) push_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tdata[17:8], m_tdata[25:18], m_tlast};
        if (expected_edges.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_edges.pop_front();
          if (got.mag !== want.mag || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last ||
              m_tdata[31:26] !== 6'd0) begin
            if (got.mag !== want.mag)
              $error("edge_res expected %0d actual %0d", want.mag, got.mag);
            if (got.row !== want.row)
              $error("out_row expected %0d actual %0d", want.row, got.row);
            if (got.col !== want.col)
              $error("out_col expected %0d actual %0d", want.col, got.col);
            if (got.last !== want.last)
              $error("frame_end expected %0d actual %0d", want.last, got.last);
            if (m_tdata[31:26] !== 6'd0)
              $error("pad expected 0 actual %0d", m_tdata[31:26]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/tb_prewitt_edge_magnitude.sv
// Testbench top for the Prewitt edge magnitude block: clock, reset, pixel and
// register stimulus, verdict. Depends on pem_pkg, the block and pem_checker.
`timescale 1ns / 100ps
module tb_prewitt_edge_magnitude;
  import pem_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk, rst;
  logic        s_tvalid, m_tready, cfg_valid;
  logic [7:0]  s_tdata;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  wire         s_tready, m_tvalid, m_tlast, cfg_ready;
  wire  [31:0] m_tdata;
  int          fail_count, pending, idle_cycles;
  int          stall_mode;

  prewitt_edge_magnitude i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pem_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls on its own pattern; mode 0 never stalls.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Watchdog: cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] px);
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sends n pixels in bursts; content picks the pixel pattern.
  task automatic send_frame(int n, int content);
    int burst;
    int idle;
    logic [7:0] px;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        idle = $urandom_range(0, 3);
        if (idle != 0) begin
          s_tvalid <= 1'b0;
          repeat (idle) @(posedge clk);
        end
        burst = $urandom_range(1, 30);
      end
      case (content)
        0: px = $urandom;
        1: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        2: px = (i % 2 == 0) ? 8'hFF : 8'h00;
        default: px = 8'hFF - 8'(i);
      endcase
      send_pixel(px);
      burst--;
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every result, then lets the pipeline drain.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_mode = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest frame, saturating patterns, and clamped sizes.
    set_frame(3, 3);
    send_frame(9, 2);
    send_frame(9, 3);
    drain();
    set_frame(1, 0);
    send_frame(9, 1);
    drain();
    // Width above range acts as 256, height above range as 1024; only a
    // few rows are sent, then a write restarts the frame.
    set_frame(511, 2047);
    stall_mode = 1;
    send_frame(256 * 2 + 20, 0);
    drain();
    // Partial row then restart by a single write.
    write_reg(RegHeight, 4);
    send_frame(9, 1);
    drain();

    // Random frames of small sizes.
    for (int f = 0; f < 10; f++) begin
      stall_mode = $urandom_range(0, 2);
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      set_frame(w, h);
      send_frame(w * h * $urandom_range(1, 2), $urandom_range(0, 1));
      drain();
    end

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### sim.f
sv/pem_pkg.sv
sv/pem_root_cell.sv
sv/pem_window.sv
sv/prewitt_edge_magnitude.sv
sv/prewitt_edge_magnitude_chk.sv
tb/sv/pem_checker.sv
tb/sv/tb_prewitt_edge_magnitude.sv
